@@ design/xcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// XOR-checked frame receiver package
// Shared widths, register indexes and result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

   localparam int ByteWidth   = 8;
   localparam int LenWidth    = 16;
   localparam int KindWidth   = 3;
   localparam int CsrIdxWidth = 2;

   // Shortest frame: sync, two length bytes, address, command, check byte.
   localparam logic [LenWidth-1:0] MinFrameLen = LenWidth'(6);

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [LenWidth-1:0]  len_type;
   typedef logic [KindWidth-1:0] kind_type;

   localparam kind_type KIND_ECHO   = 3'd0;
   localparam kind_type KIND_SUPPLY = 3'd1;
   localparam kind_type KIND_OTHER  = 3'd2;
   localparam kind_type KIND_XOR    = 3'd3;
   localparam kind_type KIND_ADDR   = 3'd4;
   localparam kind_type KIND_LEN    = 3'd5;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SYNC_VALUE  = 2'd0,
      CSR_OWN_ADDRESS = 2'd1,
      CSR_ECHO_CODE   = 2'd2,
      CSR_SUPPLY_CODE = 2'd3
   } csr_idx_type;

endpackage : xcfr_pkg

`default_nettype wire

@@ design/xcfr_req_if.sv @@
// ----------------------------------------------------------------------------
// XOR-checked frame receiver request channel
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcfr_req_if;
   import xcfr_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface : xcfr_req_if

`default_nettype wire

@@ design/xcfr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// XOR-checked frame receiver response channel
// Valid/ready channel carrying one frame report per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcfr_rsp_if;
   import xcfr_pkg::*;

   logic     valid;
   logic     ready;
   kind_type frame_kind;
   byte_type command_byte;
   len_type  frame_length;

   modport source (output valid, output frame_kind, output command_byte,
                   output frame_length, input ready);
   modport sink   (input valid, input frame_kind, input command_byte,
                   input frame_length, output ready);
endinterface : xcfr_rsp_if

`default_nettype wire

@@ design/xor_checked_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// XOR-checked frame receiver
// Hunts for a sync byte, parses length, address and command, XORs the frame
// and reports one result per completed or rejected frame.
// ----------------------------------------------------------------------------
// The byte that ends a frame is held in the input register, and its result
// is then loaded into the output register. Throughput: one byte per cycle
// while the result side keeps up; the single per-byte parser update sets it.
// Reset (synchronous, active high) returns the parser to sync hunting, clears
// all configuration registers to zero and empties both pipeline registers.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_frame_receiver_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   xcfr_req_if.sink                             req_chan,
   xcfr_rsp_if.source                           rsp_chan,
   input  wire                                  csr_wr_en,
   input  wire [xcfr_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire [xcfr_pkg::ByteWidth-1:0]        csr_wr_data
);
   import xcfr_pkg::*;

   // Parser phases, one per field position in the frame.
   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_ADDR,
      PH_CMD,
      PH_BODY
   } phase_type;

   // Configuration registers.
   byte_type sync_value_ff;
   byte_type own_address_ff;
   byte_type echo_code_ff;
   byte_type supply_code_ff;

   // Input register: holds the accepted byte until the parser takes it.
   logic     in_valid_ff;
   byte_type in_byte_ff;

   // Parser state.
   phase_type phase_ff, phase_in;
   byte_type  xor_sum_ff, xor_sum_in;
   len_type   bytes_seen_ff, bytes_seen_in;
   len_type   decl_len_ff, decl_len_in;
   byte_type  held_cmd_ff, held_cmd_in;

   // Result produced by the byte in the input register.
   logic     res_valid;
   kind_type res_kind;
   byte_type res_cmd;

   // Output register.
   logic     out_valid_ff;
   kind_type out_kind_ff;
   byte_type out_cmd_ff;
   len_type  out_len_ff;

   logic     advance;
   logic     step;
   byte_type xor_next;
   len_type  seen_next;

   // The byte in the input register moves on whenever the output register
   // is empty or is being drained in this cycle, so a waiting result never
   // blocks intake as long as the consumer takes it.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.frame_kind   = out_kind_ff;
   assign rsp_chan.command_byte = out_cmd_ff;
   assign rsp_chan.frame_length = out_len_ff;

   assign xor_next  = xor_sum_ff ^ in_byte_ff;
   assign seen_next = bytes_seen_ff + LenWidth'(1);

   // Per-byte parser update. Every byte after the sync byte joins the XOR
   // and the byte count; a rejected or finished frame returns to hunting
   // with the running sums cleared, so consumed bytes are never rescanned.
   always_comb begin
      phase_in      = phase_ff;
      xor_sum_in    = xor_next;
      bytes_seen_in = seen_next;
      decl_len_in   = decl_len_ff;
      held_cmd_in   = held_cmd_ff;
      res_valid     = 1'b0;
      res_kind      = KIND_OTHER;
      res_cmd       = '0;

      case (phase_ff)
         PH_HUNT: begin
            xor_sum_in    = xor_sum_ff;
            bytes_seen_in = bytes_seen_ff;
            if (in_byte_ff == sync_value_ff) begin
               phase_in      = PH_LEN_HI;
               xor_sum_in    = in_byte_ff;
               bytes_seen_in = LenWidth'(1);
               decl_len_in   = '0;
               held_cmd_in   = '0;
            end
         end
         PH_LEN_HI: begin
            decl_len_in = {in_byte_ff, {ByteWidth{1'b0}}};
            phase_in    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            decl_len_in = {decl_len_ff[LenWidth-1:ByteWidth], in_byte_ff};
            if (decl_len_in < MinFrameLen) begin
               // Declared length too short to hold a complete frame.
               res_valid = 1'b1;
               res_kind  = KIND_LEN;
               phase_in  = PH_HUNT;
            end else begin
               phase_in = PH_ADDR;
            end
         end
         PH_ADDR: begin
            if (in_byte_ff != own_address_ff) begin
               // Address is checked before the checksum is known.
               res_valid = 1'b1;
               res_kind  = KIND_ADDR;
               phase_in  = PH_HUNT;
            end else begin
               phase_in = PH_CMD;
            end
         end
         PH_CMD: begin
            held_cmd_in = in_byte_ff;
            phase_in    = PH_BODY;
         end
         PH_BODY: begin
            if (seen_next >= decl_len_ff) begin
               // Last declared byte: the check byte is already in the XOR.
               res_valid = 1'b1;
               res_cmd   = held_cmd_ff;
               phase_in  = PH_HUNT;
               if (xor_next != '0) begin
                  res_kind = KIND_XOR;
               end else if (held_cmd_ff == echo_code_ff) begin
                  res_kind = KIND_ECHO;
               end else if (held_cmd_ff == supply_code_ff) begin
                  res_kind = KIND_SUPPLY;
               end else begin
                  res_kind = KIND_OTHER;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase

      if (res_valid) begin
         xor_sum_in    = '0;
         bytes_seen_in = '0;
         held_cmd_in   = '0;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff  <= '0;
         own_address_ff <= '0;
         echo_code_ff   <= '0;
         supply_code_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_SYNC_VALUE:  sync_value_ff  <= csr_wr_data;
            CSR_OWN_ADDRESS: own_address_ff <= csr_wr_data;
            CSR_ECHO_CODE:   echo_code_ff   <= csr_wr_data;
            CSR_SUPPLY_CODE: supply_code_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   // Parser state advances once per byte leaving the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         xor_sum_ff    <= '0;
         bytes_seen_ff <= '0;
         decl_len_ff   <= '0;
         held_cmd_ff   <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         xor_sum_ff    <= xor_sum_in;
         bytes_seen_ff <= bytes_seen_in;
         decl_len_ff   <= decl_len_in;
         held_cmd_ff   <= held_cmd_in;
      end
   end

   // Output register: loaded with a result, held until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_kind_ff <= res_kind;
         out_cmd_ff  <= res_cmd;
         out_len_ff  <= decl_len_in;
      end
   end

endmodule : xor_checked_frame_receiver_unit

`default_nettype wire
